FILE: design/jdc_pkg.sv
package jdc_pkg;

    // Field widths of the two channels.
    localparam int JD_W       = 54;
    localparam int YEAR_W     = 12;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int SECOND_W   = 22;

    // Number of register stages from request to result.
    localparam int NSTAGE = 4;

    // Epoch 2415019.5 written as a count of half days.
    localparam logic [63:0] EPOCH_HALF_DAYS = 64'd4830039;

    // Whole days since the epoch that fall inside 1901..2099.
    localparam logic [39:0] FIRST_DAY = 40'd366;
    localparam logic [39:0] END_DAY   = 40'd73050;

    // Quarter days divided by 1461: multiply by ceil(2^30 / 1461) and shift by 30.
    // The rounding error stays below 1/1461 for every quarter-day count in range.
    localparam int          QDAY_W           = 19;
    localparam int          RECIP_W          = 20;
    localparam int          PROD_W           = QDAY_W + RECIP_W;
    localparam logic [RECIP_W-1:0] YEAR_RECIP = 20'd734937;
    localparam int          YEAR_RECIP_SHIFT = 30;

    localparam int          WHOLE_W   = 17;
    localparam int          YCOUNT_W  = 8;
    localparam int          DOY_W     = 9;
    localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1900;
    localparam logic [WHOLE_W-1:0] DAYS_PER_YEAR = 17'd365;

    // Widest seconds value before it is cut to the output field.
    localparam int SEC_WIDE_W = 30;

    localparam int MONTHS = 12;
    localparam int MONTH_IDX_W = 4;

    // Days of the year that come before each month in a common year.
    localparam logic [DOY_W-1:0] MONTH_START [MONTHS] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    localparam logic [MONTH_IDX_W-1:0] MARCH_IDX = 4'd2;

    typedef struct packed {
        logic [NSTAGE-1:0] en;
    } pipe_ctrl_t;

    function automatic logic [DOY_W-1:0] month_start(
        input logic [MONTH_IDX_W-1:0] idx,
        input logic                   leap
    );
        logic [DOY_W-1:0] s;
        s = MONTH_START[idx];
        if (leap && idx >= MARCH_IDX)
        begin
            s = s + 9'd1;
        end
        return s;
    endfunction

endpackage

FILE: design/jdc_in_if.sv
interface jdc_in_if;
    logic                        valid;
    logic                        ready;
    logic [jdc_pkg::JD_W-1:0]    julian_date;

    modport source (output valid, output julian_date, input ready);
    modport sink   (input valid, input julian_date, output ready);
endinterface

FILE: design/jdc_out_if.sv
interface jdc_out_if;
    logic                          valid;
    logic                          ready;
    logic [jdc_pkg::YEAR_W-1:0]    year_out;
    logic [jdc_pkg::MONTH_W-1:0]   month_out;
    logic [jdc_pkg::DAY_W-1:0]     day_out;
    logic [jdc_pkg::HOUR_W-1:0]    hour_out;
    logic [jdc_pkg::MINUTE_W-1:0]  minute_out;
    logic [jdc_pkg::SECOND_W-1:0]  second_out;
    logic                          range_error;

    modport source (
        output valid, output year_out, output month_out, output day_out,
        output hour_out, output minute_out, output second_out, output range_error,
        input ready
    );
    modport sink (
        input valid, input year_out, input month_out, input day_out,
        input hour_out, input minute_out, input second_out, input range_error,
        output ready
    );
endinterface

FILE: design/jdc_date_path.sv
module jdc_date_path #(
    parameter int DAY_FRACTION_BITS = 32
) (
    input  logic                          clk,
    input  jdc_pkg::pipe_ctrl_t           ctrl,
    input  logic [jdc_pkg::JD_W-1:0]      julian_date,
    output logic                          err_s3,
    output logic [jdc_pkg::YEAR_W-1:0]    year_out,
    output logic [jdc_pkg::MONTH_W-1:0]   month_out,
    output logic [jdc_pkg::DAY_W-1:0]     day_out,
    output logic                          range_error
);

    localparam int DFB = DAY_FRACTION_BITS;
    localparam logic [64:0] EPOCH = {1'b0, jdc_pkg::EPOCH_HALF_DAYS << (DFB - 1)};

    // Stage 1: days since the epoch.
    logic [64:0]                      diff;
    logic [jdc_pkg::JD_W-1:0]         t_reg, t_next;
    logic                             lt_reg, lt_next;

    // Stage 2: range check and the reciprocal product for the year.
    logic [39:0]                      whole_x;
    logic [jdc_pkg::QDAY_W-1:0]       qday;
    logic [jdc_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic [jdc_pkg::WHOLE_W-1:0]      whole_reg, whole_next;
    logic                             err2_reg, err2_next;

    // Stage 3: year and day of year.
    logic [jdc_pkg::YCOUNT_W-1:0]     y_est, y_m1, y_m2;
    logic [jdc_pkg::WHOLE_W-1:0]      base1, base0, base_sel;
    logic                             step_back;
    logic [jdc_pkg::YCOUNT_W-1:0]     y_reg, y_next;
    logic [jdc_pkg::DOY_W-1:0]        doy_reg, doy_next;
    logic                             err3_reg, err3_next;

    // Stage 4: month search and result fields.
    logic                             leap;
    logic [jdc_pkg::MONTH_IDX_W-1:0]  mon_idx;
    logic [jdc_pkg::DOY_W-1:0]        dom;
    logic [jdc_pkg::YEAR_W-1:0]       year_reg, year_next;
    logic [jdc_pkg::MONTH_W-1:0]      month_reg, month_next;
    logic [jdc_pkg::DAY_W-1:0]        day_reg, day_next;
    logic                             err4_reg;

    always_comb
    begin
        diff    = {11'd0, julian_date} - EPOCH;
        t_next  = diff[jdc_pkg::JD_W-1:0];
        lt_next = diff[64];
    end

    always_comb
    begin
        whole_x    = 40'(t_reg >> DFB);
        err2_next  = lt_reg || (whole_x < jdc_pkg::FIRST_DAY) || (whole_x >= jdc_pkg::END_DAY);
        // Quarter days since the epoch, truncated.
        qday       = {whole_x[jdc_pkg::WHOLE_W-1:0], t_reg[DFB-1 -: 2]};
        prod_next  = {{jdc_pkg::RECIP_W{1'b0}}, qday}
                   * {{jdc_pkg::QDAY_W{1'b0}}, jdc_pkg::YEAR_RECIP};
        whole_next = whole_x[jdc_pkg::WHOLE_W-1:0];
    end

    always_comb
    begin
        y_est  = prod_reg[jdc_pkg::YEAR_RECIP_SHIFT +: jdc_pkg::YCOUNT_W];
        y_m1   = y_est - 8'd1;
        y_m2   = y_est - 8'd2;
        base1  = jdc_pkg::WHOLE_W'(y_est) * jdc_pkg::DAYS_PER_YEAR
               + jdc_pkg::WHOLE_W'(y_m1 >> 2);
        base0  = jdc_pkg::WHOLE_W'(y_m1) * jdc_pkg::DAYS_PER_YEAR
               + jdc_pkg::WHOLE_W'(y_m2 >> 2);
        // A day count at or below the year start belongs to the previous year.
        step_back = (whole_reg <= base1);
        base_sel  = step_back ? base0 : base1;
        y_next    = step_back ? y_m1 : y_est;
        doy_next  = jdc_pkg::DOY_W'(whole_reg - base_sel);
        err3_next = err2_reg;
    end

    always_comb
    begin
        leap    = (y_reg[1:0] == 2'b00);
        mon_idx = '0;
        for (int m = 1; m < jdc_pkg::MONTHS; m++)
        begin
            if (doy_reg > jdc_pkg::month_start(jdc_pkg::MONTH_IDX_W'(m), leap))
            begin
                mon_idx = jdc_pkg::MONTH_IDX_W'(m);
            end
        end
        dom = doy_reg - jdc_pkg::month_start(mon_idx, leap);
        if (err3_reg)
        begin
            year_next  = '0;
            month_next = '0;
            day_next   = '0;
        end
        else
        begin
            year_next  = jdc_pkg::BASE_YEAR + jdc_pkg::YEAR_W'(y_reg);
            month_next = jdc_pkg::MONTH_W'(mon_idx) + 4'd1;
            day_next   = dom[jdc_pkg::DAY_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            t_reg  <= t_next;
            lt_reg <= lt_next;
        end
        if (ctrl.en[1])
        begin
            prod_reg  <= prod_next;
            whole_reg <= whole_next;
            err2_reg  <= err2_next;
        end
        if (ctrl.en[2])
        begin
            y_reg    <= y_next;
            doy_reg  <= doy_next;
            err3_reg <= err3_next;
        end
        if (ctrl.en[3])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            err4_reg  <= err3_reg;
        end
    end

    assign err_s3      = err3_reg;
    assign year_out    = year_reg;
    assign month_out   = month_reg;
    assign day_out     = day_reg;
    assign range_error = err4_reg;

endmodule

FILE: design/jdc_time_path.sv
module jdc_time_path #(
    parameter int DAY_FRACTION_BITS    = 32,
    parameter int SECOND_FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  jdc_pkg::pipe_ctrl_t           ctrl,
    input  logic [jdc_pkg::JD_W-1:0]      julian_date,
    input  logic                          err_s3,
    output logic [jdc_pkg::HOUR_W-1:0]    hour_out,
    output logic [jdc_pkg::MINUTE_W-1:0]  minute_out,
    output logic [jdc_pkg::SECOND_W-1:0]  second_out
);

    localparam int DFB  = DAY_FRACTION_BITS;
    localparam int SFB  = SECOND_FRACTION_BITS;
    localparam int XW1  = DFB + 5;
    localparam int XW2  = DFB + 6;
    localparam int SW   = SFB + 6;
    localparam int SWW  = jdc_pkg::SEC_WIDE_W;

    // The epoch ends in half a day, so the day fraction since the epoch is the
    // input fraction with its top bit inverted.
    logic [DFB-1:0]                   frac;
    logic [XW1-1:0]                   x1_reg, x1_next;
    logic [DFB-1:0]                   f1, f2;
    logic [XW2-1:0]                   x2_reg, x2_next;
    logic [XW2-1:0]                   x3_reg, x3_next;
    logic [jdc_pkg::HOUR_W-1:0]       hr2_reg, hr3_reg;
    logic [jdc_pkg::MINUTE_W-1:0]     mn3_reg;
    logic [SW-1:0]                    sec_full;
    logic [SWW-1:0]                   sec_wide;
    logic [jdc_pkg::HOUR_W-1:0]       hour_reg, hour_next;
    logic [jdc_pkg::MINUTE_W-1:0]     minute_reg, minute_next;
    logic [jdc_pkg::SECOND_W-1:0]     second_reg, second_next;

    assign frac    = {~julian_date[DFB-1], julian_date[DFB-2:0]};
    assign x1_next = XW1'({frac, 4'b0}) + XW1'({frac, 3'b0});

    assign f1      = x1_reg[DFB-1:0];
    assign x2_next = XW2'({f1, 6'b0}) - XW2'({f1, 2'b0});

    assign f2      = x2_reg[DFB-1:0];
    assign x3_next = XW2'({f2, 6'b0}) - XW2'({f2, 2'b0});

    if (SFB <= DFB)
    begin : g_sec_shr
        assign sec_full = x3_reg[DFB+5 : DFB-SFB];
    end
    else
    begin : g_sec_shl
        assign sec_full = {x3_reg, {(SFB-DFB){1'b0}}};
    end

    assign sec_wide = SWW'(sec_full);

    always_comb
    begin
        if (err_s3)
        begin
            hour_next   = '0;
            minute_next = '0;
            second_next = '0;
        end
        else
        begin
            hour_next   = hr3_reg;
            minute_next = mn3_reg;
            second_next = sec_wide[jdc_pkg::SECOND_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            x1_reg <= x1_next;
        end
        if (ctrl.en[1])
        begin
            x2_reg  <= x2_next;
            hr2_reg <= x1_reg[DFB +: jdc_pkg::HOUR_W];
        end
        if (ctrl.en[2])
        begin
            x3_reg  <= x3_next;
            hr3_reg <= hr2_reg;
            mn3_reg <= x2_reg[DFB +: jdc_pkg::MINUTE_W];
        end
        if (ctrl.en[3])
        begin
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
        end
    end

    assign hour_out   = hour_reg;
    assign minute_out = minute_reg;
    assign second_out = second_reg;

endmodule

FILE: design/julian_date_to_calendar.sv
// Julian date to calendar date and time of day, universal time.
//
// A request on jd_chan carries one Julian date, unsigned, with
// DAY_FRACTION_BITS fraction bits of a day. For each request one result
// leaves on cal_chan: year, month, day, hour, minute and seconds with
// SECOND_FRACTION_BITS fraction bits. Dates before 1901 or from 2100 on
// give range_error set and all other fields zero.
//
// The block is a four-stage pipeline: epoch subtraction, range check with
// the reciprocal multiply for the year, year correction and day of year,
// then the month search. The time of day runs beside it through three
// constant multiplies. One request is taken every cycle while cal_chan
// does not stall.
//
// Each stage holds its contents while the stage after it is full and
// stalled, so a stall on cal_chan backs up stage by stage and nothing is
// lost or repeated. Reset empties every stage; no result is valid after it.
module julian_date_to_calendar #(
    parameter int DAY_FRACTION_BITS    = 32,
    parameter int SECOND_FRACTION_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    jdc_in_if.sink    jd_chan,
    jdc_out_if.source cal_chan
);

    localparam int NS = jdc_pkg::NSTAGE;

    logic [NS-1:0]        valid_reg, valid_next;
    logic [NS-1:0]        stage_ready;
    jdc_pkg::pipe_ctrl_t  ctrl;
    logic                 err_s3;

    always_comb
    begin
        stage_ready[NS-1] = !valid_reg[NS-1] || cal_chan.ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = stage_ready[0] ? jd_chan.valid : valid_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.en        = stage_ready;
    assign jd_chan.ready  = stage_ready[0];
    assign cal_chan.valid = valid_reg[NS-1];

    jdc_date_path #(
        .DAY_FRACTION_BITS (DAY_FRACTION_BITS)
    ) u_date (
        .clk         (clk),
        .ctrl        (ctrl),
        .julian_date (jd_chan.julian_date),
        .err_s3      (err_s3),
        .year_out    (cal_chan.year_out),
        .month_out   (cal_chan.month_out),
        .day_out     (cal_chan.day_out),
        .range_error (cal_chan.range_error)
    );

    jdc_time_path #(
        .DAY_FRACTION_BITS    (DAY_FRACTION_BITS),
        .SECOND_FRACTION_BITS (SECOND_FRACTION_BITS)
    ) u_time (
        .clk         (clk),
        .ctrl        (ctrl),
        .julian_date (jd_chan.julian_date),
        .err_s3      (err_s3),
        .hour_out    (cal_chan.hour_out),
        .minute_out  (cal_chan.minute_out),
        .second_out  (cal_chan.second_out)
    );

endmodule

FILE: tb/tb_julian_date_to_calendar.sv
module tb_julian_date_to_calendar;

    localparam int DAY_FRAC_BITS = 32;
    localparam int SEC_FRAC_BITS = 16;
    localparam logic [63:0] JD_EPOCH = 64'd4830039 << (DAY_FRAC_BITS - 1);
    localparam logic [63:0] FIRST_WHOLE_DAY = 64'd366;
    localparam logic [63:0] END_WHOLE_DAY = 64'd73050;
    localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;

    typedef logic [jdc_pkg::JD_W-1:0] jd_t;

    typedef struct packed {
        logic [jdc_pkg::YEAR_W-1:0]   year;
        logic [jdc_pkg::MONTH_W-1:0]  month;
        logic [jdc_pkg::DAY_W-1:0]    day;
        logic [jdc_pkg::HOUR_W-1:0]   hour;
        logic [jdc_pkg::MINUTE_W-1:0] minute;
        logic [jdc_pkg::SECOND_W-1:0] second;
        logic                         range_err;
    } calendar_t;

    logic clk;
    logic rst_n;

    jdc_in_if  jd_chan ();
    jdc_out_if cal_chan ();

    julian_date_to_calendar dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .jd_chan  (jd_chan),
        .cal_chan (cal_chan)
    );

    calendar_t pending_dates [$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        stall_len = 0;
    int        stall_seq = 0;
    int        quiet_cycles = 0;

    wire jd_fire  = jd_chan.valid && jd_chan.ready;
    wire cal_fire = cal_chan.valid && cal_chan.ready;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Calendar date and time of day that the block must give for one Julian date.
    function automatic calendar_t calendar_of(input jd_t jd);
        calendar_t   r;
        logic [63:0] t;
        logic [63:0] whole;
        logic [63:0] frac;
        logic [63:0] y;
        logic [63:0] leaps;
        logic [63:0] base;
        logic [63:0] x;
        int unsigned doy;
        int unsigned mon;
        int unsigned acc;
        int unsigned mlen;
        r = '0;
        r.range_err = 1'b1;
        if (64'(jd) < JD_EPOCH)
        begin
            return r;
        end
        t = 64'(jd) - JD_EPOCH;
        whole = t >> DAY_FRAC_BITS;
        frac = {32'b0, t[31:0]};
        if (whole < FIRST_WHOLE_DAY || whole >= END_WHOLE_DAY)
        begin
            return r;
        end
        // Whole years since 1900 is floor(4t / 1461 days); it may overshoot late in a year.
        y = (t * 4) / (64'd1461 << DAY_FRAC_BITS);
        leaps = (y - 1) >> 2;
        base = y * 365 + leaps;
        if (whole <= base)
        begin
            y = y - 1;
            leaps = (y - 1) >> 2;
            base = y * 365 + leaps;
        end
        doy = int'(whole - base);
        mon = 1;
        acc = 0;
        while (mon < 12)
        begin
            mlen = MONTH_DAYS[mon - 1];
            if (mon == 2 && y[1:0] == 2'b00)
            begin
                mlen = 29;
            end
            if (doy <= acc + mlen)
            begin
                break;
            end
            acc = acc + mlen;
            mon = mon + 1;
        end
        r.year = jdc_pkg::YEAR_W'(64'd1900 + y);
        r.month = jdc_pkg::MONTH_W'(mon);
        r.day = jdc_pkg::DAY_W'(doy - acc);
        x = frac * 24;
        r.hour = jdc_pkg::HOUR_W'(x >> DAY_FRAC_BITS);
        x = {32'b0, x[31:0]} * 60;
        r.minute = jdc_pkg::MINUTE_W'(x >> DAY_FRAC_BITS);
        x = {32'b0, x[31:0]} * 60;
        r.second = jdc_pkg::SECOND_W'(x >> (DAY_FRAC_BITS - SEC_FRAC_BITS));
        r.range_err = 1'b0;
        return r;
    endfunction

    // Julian date of a calendar day in 1901..2099 plus a fraction of that day.
    function automatic jd_t at_date(input int yr, input int mo, input int dy,
                                    input logic [31:0] frac);
        logic [63:0] whole;
        int          ys;
        ys = yr - 1900;
        whole = 64'(ys * 365 + (ys - 1) / 4 + dy);
        for (int m = 1; m < mo; m++)
        begin
            whole = whole + 64'((m == 2 && ys % 4 == 0) ? 29 : MONTH_DAYS[m - 1]);
        end
        return jd_t'(JD_EPOCH + (whole << DAY_FRAC_BITS) + {32'b0, frac});
    endfunction

    function automatic logic [31:0] random_frac();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic jd_t random_date();
        int          pick;
        logic [63:0] edge_day;
        logic [63:0] offset;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            return jd_t'(JD_EPOCH + (64'($urandom_range(366, 73049)) << DAY_FRAC_BITS)
                         + {32'b0, random_frac()});
        end
        else if (pick < 85)
        begin
            // First and last days of a year; on the last day the year estimate may need stepping back.
            if ($urandom_range(0, 1) == 0)
            begin
                return at_date($urandom_range(1901, 2099), 1, 1, random_frac());
            end
            return at_date($urandom_range(1901, 2099), 12, 31, random_frac());
        end
        else if (pick < 92)
        begin
            edge_day = ($urandom_range(0, 1) == 0) ? FIRST_WHOLE_DAY : END_WHOLE_DAY;
            offset = {31'b0, 1'($urandom_range(0, 1)), $urandom};
            if ($urandom_range(0, 1) == 0)
            begin
                return jd_t'(JD_EPOCH + (edge_day << DAY_FRAC_BITS) + offset);
            end
            return jd_t'(JD_EPOCH + (edge_day << DAY_FRAC_BITS) - offset - 64'd1);
        end
        return jd_t'({$urandom, $urandom});
    endfunction

    // Offers one request and returns at the edge where it is taken.
    task automatic send_date(input jd_t jd);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            jd_chan.valid <= 1'b0;
            @(posedge clk);
        end
        jd_chan.valid <= 1'b1;
        jd_chan.julian_date <= jd;
        @(posedge clk);
        while (!jd_chan.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed_dates();
        send_date('0);
        send_date('1);
        send_date(jd_t'(JD_EPOCH - 64'd1));
        send_date(jd_t'(JD_EPOCH));
        send_date(at_date(1901, 1, 1, 32'h0) - jd_t'(1));
        send_date(at_date(1901, 1, 1, 32'h0));
        send_date(at_date(1901, 2, 28, 32'hFFFF_FFFF));
        send_date(at_date(1901, 3, 1, 32'h0));
        send_date(at_date(1904, 2, 29, 32'h8000_0000));
        send_date(at_date(1904, 3, 1, 32'h4000_0000));
        send_date(at_date(1904, 12, 31, 32'h0));
        send_date(at_date(1904, 12, 31, 32'hC000_0000));
        send_date(at_date(1904, 12, 31, 32'hFFFF_FFFF));
        send_date(at_date(1905, 1, 1, 32'h0));
        send_date(at_date(1969, 7, 20, 32'h8AAA_AAAB));
        send_date(at_date(1999, 12, 31, 32'hFFFF_FFFF));
        send_date(at_date(2000, 2, 29, 32'h0));
        send_date(at_date(2000, 12, 31, 32'hFFFF_FFFF));
        send_date(at_date(2050, 6, 30, 32'h1234_5678));
        send_date(at_date(2099, 12, 31, 32'hFFFF_FFFF));
        send_date(at_date(2099, 12, 31, 32'hFFFF_FFFF) + jd_t'(1));
    endtask

    task automatic test_random_dates(input int count);
        repeat (count)
        begin
            send_date(random_date());
        end
    endtask

    // The receiver stops for a long stretch while requests keep coming, so the
    // pipeline fills and has to hold its input off.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_len = 300;
        stall_seq = stall_seq + 1;
        test_random_dates(40);
    endtask

    initial
    begin
        int hold_left;
        int seen_seq;
        hold_left = 0;
        seen_seq = 0;
        cal_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_seq != seen_seq)
            begin
                seen_seq = stall_seq;
                hold_left = stall_len;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                cal_chan.ready <= 1'b0;
            end
            else
            begin
                cal_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && jd_fire)
        begin
            pending_dates.push_back(calendar_of(jd_chan.julian_date));
        end
    end

    always @(posedge clk)
    begin
        calendar_t got;
        calendar_t want;
        if (rst_n && cal_fire)
        begin
            got.year = cal_chan.year_out;
            got.month = cal_chan.month_out;
            got.day = cal_chan.day_out;
            got.hour = cal_chan.hour_out;
            got.minute = cal_chan.minute_out;
            got.second = cal_chan.second_out;
            got.range_err = cal_chan.range_error;
            if (pending_dates.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: result with no request waiting: %0d-%0d-%0d %0d:%0d",
                             $realtime, got.year, got.month, got.day, got.hour,
                             got.minute);
                    $display("%0t:   s=%0h err=%0b", $realtime, got.second, got.range_err);
                end
            end
            else
            begin
                want = pending_dates.pop_front();
                if (got.year !== want.year || got.month !== want.month
                    || got.day !== want.day || got.hour !== want.hour
                    || got.minute !== want.minute || got.second !== want.second
                    || got.range_err !== want.range_err)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: expected %0d-%0d-%0d %0d:%0d s=%0h err=%0b",
                                 $realtime, want.year, want.month, want.day, want.hour,
                                 want.minute, want.second, want.range_err);
                        $display("%0t:   actual %0d-%0d-%0d %0d:%0d s=%0h err=%0b",
                                 $realtime, got.year, got.month, got.day, got.hour,
                                 got.minute, got.second, got.range_err);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (jd_fire || cal_fire)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        jd_chan.valid <= 1'b0;
        jd_chan.julian_date <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 88;
        test_directed_dates();
        test_random_dates(170);

        send_idle_pct = 88;
        recv_idle_pct = 34;
        test_random_dates(170);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_dates(170);

        test_output_stall();

        jd_chan.valid <= 1'b0;
        while (pending_dates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_dates.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
